// File: hdl/lmds_pkg.sv
// Shared types, codes and the glyph font for the LED-matrix frame sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lmds_pkg;

    typedef enum logic [1:0] {
        OP_SHOW  = 2'd0,
        OP_INIT  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_INTENSITY = 2'd0,
        CFG_SCAN      = 2'd1,
        CFG_DECODE    = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // Driver chip register addresses
    localparam logic [3:0] REG_SHUTDOWN  = 4'h0C;
    localparam logic [3:0] REG_SCAN      = 4'h0B;
    localparam logic [3:0] REG_DECODE    = 4'h09;
    localparam logic [3:0] REG_INTENSITY = 4'h0A;
    localparam logic [3:0] REG_TEST      = 4'h0F;

    localparam logic [7:0] DATA_WAKE     = 8'h01;
    localparam logic [7:0] DATA_ZERO     = 8'h00;

    localparam logic [3:0] RESET_INTENSITY = 4'd15;
    localparam logic [2:0] RESET_SCAN      = 3'd7;
    localparam logic [7:0] RESET_DECODE    = 8'h00;

    // Frame counter end points per command
    localparam logic [2:0] SHOW_PAIR_END  = 3'd3;
    localparam logic [2:0] SHOW_ROW_END   = 3'd7;
    localparam logic [2:0] INIT_STEP_END  = 3'd4;
    localparam logic [2:0] CLEAR_ROW_END  = 3'd7;
    localparam logic [2:0] CHIP_END       = 3'd3;

    // Init sequence steps within one chip
    localparam logic [2:0] INIT_WAKE      = 3'd0;
    localparam logic [2:0] INIT_SCAN      = 3'd1;
    localparam logic [2:0] INIT_DECODE    = 3'd2;
    localparam logic [2:0] INIT_INTENSITY = 3'd3;

    // Font: nibble r (bits 4r+3..4r) is row r; codes 10, 14 and 15 are blank.
    localparam logic [31:0] FONT [16] = '{
        32'h00EAAAE0, 32'h00444440, 32'h00E8E2E0, 32'h00E8C8E0,
        32'h00AAE880, 32'h00E2E8E0, 32'h00E2EAE0, 32'h00E88880,
        32'h00EAEAE0, 32'h00EAE8E0, 32'h00000000, 32'h01C44C00,
        32'h00A4A000, 32'h01C4C440, 32'h00000000, 32'h00000000
    };

    function automatic logic [3:0] glyph_row(input logic [3:0] code,
                                             input logic [2:0] ridx);
        logic [31:0] rows;
        rows = FONT[code];
        return rows[{ridx, 2'b00} +: 4];
    endfunction

    typedef struct packed {
        logic load;   // take a new request into the datapath
        logic step;   // emit one frame and advance the counters
    } t_ctrl_cmd;

    typedef struct packed {
        logic frame_last;  // current frame is the final one of the request
        logic out_free;    // output register can take a frame this cycle
    } t_dp_status;

endpackage

`default_nettype wire

// File: hdl/led_matrix_digit_frame_sequencer.sv
// LED-matrix digit frame sequencer. Each request on the input channel is
// one command for a chain of four LED-matrix driver chips and turns into a
// burst of register frames (address, data) on the output channel, one
// frame per cycle while the output is not stalled. Show writes rows 8 down
// to 1 for glyph pairs (7,6), (5,4), (3,2), (1,0): 32 frames, latch mark
// after every fourth. Init writes shutdown-exit, scan limit, decode mode,
// intensity and test-off to each chip: 20 frames, latch after each fifth.
// Clear zeroes rows 1..8 of each chip: 32 frames, latch after each eighth.
// The last frame of a request carries the last flag. Opcode 3 is taken
// and produces nothing. The next request is taken as soon as the final
// frame sits in the output register, even while that frame still waits.
// Configuration writes (index 0 intensity, 1 scan limit, 2 decode mask,
// 3 ignored) take effect at once; write them only while no request is in
// progress.
// Depends on lmds_pkg, lmds_ctrl and lmds_dp.
`default_nettype none

module led_matrix_digit_frame_sequencer
    import lmds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration write port
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    // request channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [3:0] i_glyph0,
    input  wire logic [3:0] i_glyph1,
    input  wire logic [3:0] i_glyph2,
    input  wire logic [3:0] i_glyph3,
    input  wire logic [3:0] i_glyph4,
    input  wire logic [3:0] i_glyph5,
    input  wire logic [3:0] i_glyph6,
    input  wire logic [3:0] i_glyph7,
    // frame channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_reg_address,
    output logic [7:0]      o_reg_data,
    output logic            o_latch_after,
    output logic            o_last
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Sequencing: idle until a request arrives, then step out frames.
    lmds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Frame generation, config registers and the output register.
    lmds_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_glyph0      (i_glyph0),
        .i_glyph1      (i_glyph1),
        .i_glyph2      (i_glyph2),
        .i_glyph3      (i_glyph3),
        .i_glyph4      (i_glyph4),
        .i_glyph5      (i_glyph5),
        .i_glyph6      (i_glyph6),
        .i_glyph7      (i_glyph7),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_reg_address (o_reg_address),
        .o_reg_data    (o_reg_data),
        .o_latch_after (o_latch_after),
        .o_last        (o_last)
    );

    // A request is never taken in the same cycle a frame is stepped out.
    a_load_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && cmd.step))
        else $error("request load and frame step in the same cycle");

    // Stepping out the final frame frees the request side next cycle.
    a_last_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && status.frame_last) |=> !o_in_stall)
        else $error("request side still stalled after final frame");

    // A stepped frame shows up as valid output in the next cycle.
    a_step_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |=> o_out_valid)
        else $error("frame stepped but output not valid");

    // The last flag always comes with a latch mark.
    a_last_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> o_latch_after)
        else $error("last frame without latch mark");

endmodule

`default_nettype wire

// File: hdl/lmds_ctrl.sv
// Controller state machine of the LED-matrix frame sequencer.
// Depends on lmds_pkg for the state, opcode and command/status types.
`default_nettype none

module lmds_ctrl
    import lmds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_opcode,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd,
    output logic            o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                // an unused opcode is taken and dropped
                if (i_in_valid && (t_opcode'(i_opcode) != OP_NONE)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.step = i_status.out_free;
                if (i_status.out_free && i_status.frame_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/lmds_dp.sv
// Datapath of the LED-matrix frame sequencer: config registers, request
// registers, frame counters and the output register. Depends on lmds_pkg.
`default_nettype none

module lmds_dp
    import lmds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_ctrl_cmd  i_cmd,
    output t_dp_status      o_status,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic [1:0] i_opcode,
    input  wire logic [3:0] i_glyph0,
    input  wire logic [3:0] i_glyph1,
    input  wire logic [3:0] i_glyph2,
    input  wire logic [3:0] i_glyph3,
    input  wire logic [3:0] i_glyph4,
    input  wire logic [3:0] i_glyph5,
    input  wire logic [3:0] i_glyph6,
    input  wire logic [3:0] i_glyph7,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_reg_address,
    output logic [7:0]      o_reg_data,
    output logic            o_latch_after,
    output logic            o_last
);

    logic [3:0]  r_intensity;
    logic [2:0]  r_scan;
    logic [7:0]  r_decode;

    t_opcode     r_op;
    logic [31:0] r_glyphs;   // pair to show sits in the top byte
    logic [2:0]  r_minor;
    logic [2:0]  r_major;

    logic        r_out_valid;
    logic [3:0]  r_addr;
    logic [7:0]  r_data;
    logic        r_latch;
    logic        r_last;

    logic        minor_end;
    logic        major_end;
    logic [3:0]  f_addr;
    logic [7:0]  f_data;
    logic [2:0]  show_ridx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intensity <= RESET_INTENSITY;
            r_scan      <= RESET_SCAN;
            r_decode    <= RESET_DECODE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_INTENSITY: r_intensity <= i_cfg_data[3:0];
                CFG_SCAN:      r_scan      <= i_cfg_data[2:0];
                CFG_DECODE:    r_decode    <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (r_op)
            OP_SHOW:  minor_end = (r_minor == SHOW_PAIR_END);
            OP_INIT:  minor_end = (r_minor == INIT_STEP_END);
            OP_CLEAR: minor_end = (r_minor == CLEAR_ROW_END);
            default:  minor_end = 1'b1;
        endcase
        if (r_op == OP_SHOW) begin
            major_end = (r_major == SHOW_ROW_END);
        end else begin
            major_end = (r_major == CHIP_END);
        end
    end

    assign show_ridx = SHOW_ROW_END - r_major;

    always_comb begin
        f_addr = 4'd0;
        f_data = DATA_ZERO;
        unique case (r_op)
            OP_SHOW: begin
                f_addr = 4'd8 - {1'b0, r_major};
                f_data = {glyph_row(r_glyphs[31:28], show_ridx),
                          glyph_row(r_glyphs[27:24], show_ridx)};
            end
            OP_INIT: begin
                priority case (r_minor)
                    INIT_WAKE: begin
                        f_addr = REG_SHUTDOWN;
                        f_data = DATA_WAKE;
                    end
                    INIT_SCAN: begin
                        f_addr = REG_SCAN;
                        f_data = {5'd0, r_scan};
                    end
                    INIT_DECODE: begin
                        f_addr = REG_DECODE;
                        f_data = r_decode;
                    end
                    INIT_INTENSITY: begin
                        f_addr = REG_INTENSITY;
                        f_data = {4'd0, r_intensity};
                    end
                    default: begin
                        f_addr = REG_TEST;
                        f_data = DATA_ZERO;
                    end
                endcase
            end
            OP_CLEAR: begin
                f_addr = {1'b0, r_minor} + 4'd1;
                f_data = DATA_ZERO;
            end
            default: begin
                f_addr = 4'd0;
                f_data = DATA_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_opcode'(i_opcode);
            r_glyphs <= {i_glyph7, i_glyph6, i_glyph5, i_glyph4,
                         i_glyph3, i_glyph2, i_glyph1, i_glyph0};
            r_minor  <= 3'd0;
            r_major  <= 3'd0;
        end else if (i_cmd.step) begin
            // rotate so the next pair moves to the top byte
            r_glyphs <= {r_glyphs[23:0], r_glyphs[31:24]};
            if (minor_end) begin
                r_minor <= 3'd0;
                r_major <= r_major + 3'd1;
            end else begin
                r_minor <= r_minor + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_addr  <= f_addr;
            r_data  <= f_data;
            r_latch <= minor_end;
            r_last  <= minor_end && major_end;
        end
    end

    assign o_status.frame_last = minor_end && major_end;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_reg_address = r_addr;
    assign o_reg_data    = r_data;
    assign o_latch_after = r_latch;
    assign o_last        = r_last;

endmodule

`default_nettype wire
